// ----- rtl/core/priority_run_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// Priority run queue core: assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUN_QUEUE_CORE_MACROS_SVH
`define PRIORITY_RUN_QUEUE_CORE_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority run queue package
// Shared constants, codes and the request beat type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

    localparam int NUM_PROCS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 32;
    localparam int PROC_IDX_W     = 6;
    localparam int PRIO_W         = 7;
    localparam int LEVEL_SHIFT    = 2;
    localparam int MASK_W         = 32;
    localparam int ERR_W          = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } prq_op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK,
        ERR_DUP_INSERT,
        ERR_EMPTY_LEVEL,
        ERR_NOT_QUEUED
    } prq_err_t;

    typedef struct packed {
        prq_op_t               op;
        logic [PROC_IDX_W-1:0] proc;
        logic [PRIO_W-1:0]     prio;
    } prq_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/priority_run_queue_core.sv -----
// ----------------------------------------------------------------------------
// Priority run queue core
// Multilevel run queue with per-level FIFO rings and a non-empty level bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_ channel inserts a process at the tail of its level or
//   removes it from wherever it sits in its ring. The level is the priority
//   shifted right by two, saturated to the top level. Each request gives one
//   beat on the m_ channel: the bitmap of non-empty levels after the request
//   and an error code.
//   Flow: an accepted request waits in the input register and moves to the
//   result register once that is free. Throughput: one request per cycle
//   while results are taken. The link memories are read at the request's
//   process index as the beat is accepted and written as it leaves the input
//   register; a bypass covers back-to-back requests on the same entry.
//   Reset: all levels empty, the bitmap zero; no clearing pass is needed, so
//   s_ready is already high while reset is held.
//   Stall: while m_ready is low the result is held, one more request can wait
//   in the input register, and then s_ready falls until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_run_queue_core #(
    parameter int NUM_PROCS  = prq_pkg::NUM_PROCS_DEF,
    parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [prq_pkg::PROC_IDX_W-1:0]    s_process_index,
    input  logic [prq_pkg::PRIO_W-1:0]        s_priority_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prq_pkg::MASK_W-1:0]        m_nonempty_mask,
    output logic [prq_pkg::ERR_W-1:0]         m_error
);

    localparam int PW  = $clog2(NUM_PROCS);
    localparam int NW  = $clog2(NUM_PROCS + NUM_LEVELS);
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int PIW = ((PW > prq_pkg::PROC_IDX_W) ? PW : prq_pkg::PROC_IDX_W) + 1;

    prq_pkg::prq_item_t             item_reg;
    logic                           item_valid_reg, item_valid_next;
    logic                           m_valid_reg, m_valid_next;
    logic [prq_pkg::MASK_W-1:0]     m_mask_reg;
    prq_pkg::prq_err_t              m_err_reg;

    logic                           accept;
    logic                           fire;
    logic [PIW-1:0]                 s_idx_wide;
    logic [PW-1:0]                  rd_addr;

    logic [NW-1:0]                  nlink_rd, plink_rd;
    logic [LW-1:0]                  lev_rd;
    logic                           nlink_we, plink_we, lev_we;
    logic [PW-1:0]                  nlink_wa, plink_wa, lev_wa;
    logic [NW-1:0]                  nlink_wd, plink_wd;
    logic [LW-1:0]                  lev_wd;
    logic [prq_pkg::MASK_W-1:0]     mask_next;
    prq_pkg::prq_err_t              err;

    assign fire    = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    assign s_idx_wide = PIW'(s_process_index);
    assign rd_addr    = s_idx_wide[PW-1:0];

    always_comb begin
        item_valid_next = item_valid_reg;
        if (accept) begin
            item_valid_next = 1'b1;
        end else if (fire) begin
            item_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op   <= prq_pkg::prq_op_t'(s_operation);
            item_reg.proc <= s_process_index;
            item_reg.prio <= s_priority_req;
        end
        if (fire) begin
            m_mask_reg <= mask_next;
            m_err_reg  <= err;
        end
    end

    prq_link_mem #(
        .DEPTH (NUM_PROCS),
        .AW    (PW),
        .DW    (NW)
    ) u_next_link (
        .clk     (aclk),
        .rst_n   (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (nlink_we),
        .wr_addr (nlink_wa),
        .wr_data (nlink_wd),
        .rd_data (nlink_rd)
    );

    prq_link_mem #(
        .DEPTH (NUM_PROCS),
        .AW    (PW),
        .DW    (NW)
    ) u_prev_link (
        .clk     (aclk),
        .rst_n   (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (plink_we),
        .wr_addr (plink_wa),
        .wr_data (plink_wd),
        .rd_data (plink_rd)
    );

    // Level each queued process was inserted at, used to close its ring.
    prq_link_mem #(
        .DEPTH (NUM_PROCS),
        .AW    (PW),
        .DW    (LW)
    ) u_proc_level (
        .clk     (aclk),
        .rst_n   (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (lev_we),
        .wr_addr (lev_wa),
        .wr_data (lev_wd),
        .rd_data (lev_rd)
    );

    prq_queue_state #(
        .NUM_PROCS  (NUM_PROCS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_state (
        .clk       (aclk),
        .rst_n     (aresetn),
        .fire      (fire),
        .item      (item_reg),
        .nlink_rd  (nlink_rd),
        .plink_rd  (plink_rd),
        .lev_rd    (lev_rd),
        .nlink_we  (nlink_we),
        .nlink_wa  (nlink_wa),
        .nlink_wd  (nlink_wd),
        .plink_we  (plink_we),
        .plink_wa  (plink_wa),
        .plink_wd  (plink_wd),
        .lev_we    (lev_we),
        .lev_wa    (lev_wa),
        .lev_wd    (lev_wd),
        .mask_next (mask_next),
        .err       (err)
    );

    assign m_valid         = m_valid_reg;
    assign m_nonempty_mask = m_mask_reg;
    assign m_error         = m_err_reg;

endmodule

`default_nettype wire

// ----- rtl/core/prq_link_mem.sv -----
// ----------------------------------------------------------------------------
// Priority run queue link memory
// One write port and one registered read port, with a bypass so that a read
// issued in the cycle of a write to the same entry returns the new data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prq_link_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_hit_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            byp_hit_reg <= 1'b0;
        end else if (rd_en) begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/prq_queue_state.sv -----
// ----------------------------------------------------------------------------
// Priority run queue state and update logic
// Holds the level heads and tails, the queued and tail flags and the level
// bitmap, and works out the link writes for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "priority_run_queue_core_macros.svh"

module prq_queue_state #(
    parameter int NUM_PROCS  = prq_pkg::NUM_PROCS_DEF,
    parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
    localparam int PW = $clog2(NUM_PROCS),
    localparam int NW = $clog2(NUM_PROCS + NUM_LEVELS),
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  prq_pkg::prq_item_t            item,
    input  logic [NW-1:0]                 nlink_rd,
    input  logic [NW-1:0]                 plink_rd,
    input  logic [LW-1:0]                 lev_rd,
    output logic                          nlink_we,
    output logic [PW-1:0]                 nlink_wa,
    output logic [NW-1:0]                 nlink_wd,
    output logic                          plink_we,
    output logic [PW-1:0]                 plink_wa,
    output logic [NW-1:0]                 plink_wd,
    output logic                          lev_we,
    output logic [PW-1:0]                 lev_wa,
    output logic [LW-1:0]                 lev_wd,
    output logic [prq_pkg::MASK_W-1:0]    mask_next,
    output prq_pkg::prq_err_t             err
);

    localparam int PIW = ((PW > prq_pkg::PROC_IDX_W) ? PW : prq_pkg::PROC_IDX_W) + 1;
    localparam int BMW = (NUM_LEVELS > prq_pkg::MASK_W) ? NUM_LEVELS : prq_pkg::MASK_W;
    localparam int RAW_W = prq_pkg::PRIO_W - prq_pkg::LEVEL_SHIFT;

    logic [NUM_PROCS-1:0]  queued_reg, queued_next;
    logic [NUM_PROCS-1:0]  tail_flag_reg, tail_flag_next;
    logic [NW-1:0]         head_reg [NUM_LEVELS];
    logic [NW-1:0]         head_next [NUM_LEVELS];
    logic [NW-1:0]         tail_reg [NUM_LEVELS];
    logic [NW-1:0]         tail_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] bitmap_reg, bitmap_next;

    logic [PIW-1:0]        p_wide;
    logic                  p_ok;
    logic [PW-1:0]         p_idx;
    logic [RAW_W-1:0]      lvl_raw;
    logic [LW-1:0]         lvl;
    logic [NUM_LEVELS-1:0] lvl_bit;
    logic [NW-1:0]         hdr;
    logic [NW-1:0]         node_f, node_b, last;
    logic                  f_hdr, b_hdr, last_hdr;
    logic [LW-1:0]         f_lvl, b_lvl;
    logic                  nlink_wr, plink_wr, lev_wr;
    logic [BMW-1:0]        bitmap_ext;

    // Request decode: process range check and level saturation.
    always_comb begin
        p_wide  = PIW'(item.proc);
        p_ok    = p_wide < PIW'(NUM_PROCS);
        p_idx   = p_wide[PW-1:0];
        lvl_raw = item.prio[prq_pkg::PRIO_W-1:prq_pkg::LEVEL_SHIFT];
        if (7'(lvl_raw) >= 7'(NUM_LEVELS)) begin
            lvl = LW'(NUM_LEVELS - 1);
        end else begin
            lvl = LW'(lvl_raw);
        end
        lvl_bit      = '0;
        lvl_bit[lvl] = 1'b1;
        hdr          = NW'(NUM_PROCS) + NW'(lvl);
    end

    // The tail of a ring points back at its level header; that link is not
    // kept in the memory but rebuilt from the tail flag and the stored level.
    always_comb begin
        node_f   = tail_flag_reg[p_idx] ? (NW'(NUM_PROCS) + NW'(lev_rd)) : nlink_rd;
        node_b   = plink_rd;
        last     = tail_reg[lvl];
        f_hdr    = node_f >= NW'(NUM_PROCS);
        b_hdr    = node_b >= NW'(NUM_PROCS);
        last_hdr = last >= NW'(NUM_PROCS);
        f_lvl    = LW'(node_f - NW'(NUM_PROCS));
        b_lvl    = LW'(node_b - NW'(NUM_PROCS));
    end

    always_comb begin
        queued_next    = queued_reg;
        tail_flag_next = tail_flag_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        bitmap_next    = bitmap_reg;
        nlink_wr       = 1'b0;
        nlink_wa       = p_idx;
        nlink_wd       = node_f;
        plink_wr       = 1'b0;
        plink_wa       = p_idx;
        plink_wd       = last;
        lev_wr         = 1'b0;
        lev_wa         = p_idx;
        lev_wd         = lvl;
        err            = prq_pkg::ERR_OK;
        if (p_ok) begin
            if (item.op == prq_pkg::OP_INSERT) begin
                if (queued_reg[p_idx]) begin
                    err = prq_pkg::ERR_DUP_INSERT;
                end else begin
                    plink_wr                = 1'b1;
                    lev_wr                  = 1'b1;
                    tail_flag_next[p_idx]   = 1'b1;
                    queued_next[p_idx]      = 1'b1;
                    tail_next[lvl]          = NW'(p_idx);
                    if (last_hdr) begin
                        head_next[lvl] = NW'(p_idx);
                    end else begin
                        nlink_wr                     = 1'b1;
                        nlink_wa                     = last[PW-1:0];
                        nlink_wd                     = NW'(p_idx);
                        tail_flag_next[last[PW-1:0]] = 1'b0;
                    end
                    bitmap_next = bitmap_reg | lvl_bit;
                end
            end else begin
                if ((bitmap_reg & lvl_bit) == '0) begin
                    err = prq_pkg::ERR_EMPTY_LEVEL;
                end else if (!queued_reg[p_idx]) begin
                    err = prq_pkg::ERR_NOT_QUEUED;
                end else begin
                    if (f_hdr) begin
                        tail_next[f_lvl] = node_b;
                    end else begin
                        plink_wr = 1'b1;
                        plink_wa = node_f[PW-1:0];
                        plink_wd = node_b;
                    end
                    if (b_hdr) begin
                        head_next[b_lvl] = node_f;
                    end else begin
                        nlink_wr                       = 1'b1;
                        nlink_wa                       = node_b[PW-1:0];
                        nlink_wd                       = node_f;
                        tail_flag_next[node_b[PW-1:0]] = f_hdr;
                    end
                    queued_next[p_idx] = 1'b0;
                    // The emptiness test looks at the requested level only.
                    if (head_next[lvl] == hdr) begin
                        bitmap_next = bitmap_reg & ~lvl_bit;
                    end
                end
            end
        end
    end

    assign nlink_we   = fire && nlink_wr;
    assign plink_we   = fire && plink_wr;
    assign lev_we     = fire && lev_wr;
    assign bitmap_ext = BMW'(bitmap_next);
    assign mask_next  = bitmap_ext[prq_pkg::MASK_W-1:0];

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            queued_reg <= '0;
            bitmap_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= NW'(NUM_PROCS + i);
                tail_reg[i] <= NW'(NUM_PROCS + i);
            end
        end else if (fire) begin
            queued_reg <= queued_next;
            bitmap_reg <= bitmap_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            tail_flag_reg <= tail_flag_next;
        end
    end

    `PRQ_ASSERT_SAME(a_ring_ends_agree, clk, rst_n, fire, (head_reg[lvl] == hdr) == (tail_reg[lvl] == hdr), "level head and tail disagree on emptiness")
    `PRQ_ASSERT_NEXT(a_insert_sets_bit, clk, rst_n, fire && p_ok && (item.op == prq_pkg::OP_INSERT) && (err == prq_pkg::ERR_OK), (bitmap_reg & $past(lvl_bit)) != '0, "insert left its level bit clear")
    `PRQ_ASSERT_NEXT(a_error_keeps_bitmap, clk, rst_n, fire && (err != prq_pkg::ERR_OK), $stable(bitmap_reg), "rejected request changed the bitmap")
    `PRQ_ASSERT_NEXT(a_remove_clears_flag, clk, rst_n, fire && p_ok && (item.op == prq_pkg::OP_REMOVE) && (err == prq_pkg::ERR_OK), !queued_reg[$past(p_idx)], "removed process still marked queued")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Priority run queue core testbench
// Drives insert and remove requests through the request channel and checks
// every result beat against a cycle-free model of the level rings and the
// non-empty bitmap. A short table of directed requests comes first, then
// random traffic that is mostly well-formed, with random idling on both
// sides, a long receiver hold-off and pauses that drain the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_PROCS    = prq_pkg::NUM_PROCS_DEF;
    localparam int NUM_LEVELS   = prq_pkg::NUM_LEVELS_DEF;
    localparam int PROC_IDX_W   = prq_pkg::PROC_IDX_W;
    localparam int PRIO_W       = prq_pkg::PRIO_W;
    localparam int MASK_W       = prq_pkg::MASK_W;
    localparam int ERR_W        = prq_pkg::ERR_W;
    localparam int LEVEL_SHIFT  = prq_pkg::LEVEL_SHIFT;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DIRECTED_N   = 23;
    localparam int IDLE_PCT     = 9;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_LEN     = 80;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        prq_pkg::prq_err_t err;
    } run_result_t;

    typedef struct packed {
        prq_pkg::prq_op_t      op;
        logic [PROC_IDX_W-1:0] proc;
        logic [PRIO_W-1:0]     prio;
        logic                  known;
        logic [MASK_W-1:0]     mask;
        prq_pkg::prq_err_t     err;
    } stim_row_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_operation     = 1'b0;
    logic [PROC_IDX_W-1:0] s_process_index = '0;
    logic [PRIO_W-1:0]     s_priority_req  = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [MASK_W-1:0]     m_nonempty_mask;
    logic [ERR_W-1:0]      m_error;

    // Model of the run queue. Node values below NUM_PROCS name a process,
    // NUM_PROCS + L names the header of level L.
    logic [6:0]        ring_next [NUM_PROCS];
    logic [6:0]        ring_prev [NUM_PROCS];
    logic [6:0]        ring_head [NUM_LEVELS];
    logic [6:0]        ring_tail [NUM_LEVELS];
    logic              in_queue  [NUM_PROCS];
    logic [4:0]        home_level[NUM_PROCS];
    logic [MASK_W-1:0] level_bits;

    run_result_t pending_results[$];
    stim_row_t   directed_rows[DIRECTED_N];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          calm_run = 1'b0;

    priority_run_queue_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_process_index (s_process_index),
        .s_priority_req  (s_priority_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nonempty_mask (m_nonempty_mask),
        .m_error         (m_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("priority_run_queue_core verification failed");
            $finish;
        end
    end

    function automatic void set_next(input logic [6:0] node, input logic [6:0] v);
        if (node < NUM_PROCS)
            ring_next[node[5:0]] = v;
        else
            ring_head[5'(node - NUM_PROCS)] = v;
    endfunction

    function automatic void set_prev(input logic [6:0] node, input logic [6:0] v);
        if (node < NUM_PROCS)
            ring_prev[node[5:0]] = v;
        else
            ring_tail[5'(node - NUM_PROCS)] = v;
    endfunction

    function automatic void run_queue_reset();
        for (int k = 0; k < NUM_PROCS; k++) begin
            in_queue[k]   = 1'b0;
            home_level[k] = '0;
        end
        for (int k = 0; k < NUM_LEVELS; k++) begin
            ring_head[k] = 7'(NUM_PROCS + k);
            ring_tail[k] = 7'(NUM_PROCS + k);
        end
        level_bits = '0;
    endfunction

    function automatic run_result_t run_queue_apply(input prq_pkg::prq_op_t op,
                                                    input logic [PROC_IDX_W-1:0] p,
                                                    input logic [PRIO_W-1:0] prio);
        logic [4:0]  lvl;
        logic [6:0]  hdr;
        logic [6:0]  last;
        logic [6:0]  fwd;
        logic [6:0]  back;
        run_result_t r;
        // A 7-bit priority shifted by two never passes the top level.
        lvl   = 5'(prio >> LEVEL_SHIFT);
        hdr   = 7'(NUM_PROCS + lvl);
        r.err = prq_pkg::ERR_OK;
        if (op == prq_pkg::OP_INSERT) begin
            if (in_queue[p]) begin
                r.err = prq_pkg::ERR_DUP_INSERT;
            end else begin
                last           = ring_tail[lvl];
                ring_next[p]   = hdr;
                ring_prev[p]   = last;
                ring_tail[lvl] = 7'(p);
                set_next(last, 7'(p));
                in_queue[p]     = 1'b1;
                home_level[p]   = lvl;
                level_bits[lvl] = 1'b1;
            end
        end else begin
            if (!level_bits[lvl]) begin
                r.err = prq_pkg::ERR_EMPTY_LEVEL;
            end else if (!in_queue[p]) begin
                r.err = prq_pkg::ERR_NOT_QUEUED;
            end else begin
                // Unlinks from the ring that really holds the process; the
                // emptiness test still looks at the requested level.
                fwd  = ring_next[p];
                back = ring_prev[p];
                set_prev(fwd, back);
                set_next(back, fwd);
                in_queue[p] = 1'b0;
                if (ring_head[lvl] == hdr)
                    level_bits[lvl] = 1'b0;
            end
        end
        r.mask = level_bits;
        return r;
    endfunction

    // Offers one request beat, then predicts its result once it is taken.
    // s_valid is left high so that the next beat can follow at once.
    task automatic offer_request(input prq_pkg::prq_op_t op,
                                 input logic [PROC_IDX_W-1:0] p,
                                 input logic [PRIO_W-1:0] prio, input logic known,
                                 input run_result_t typed);
        run_result_t got;
        while (!calm_run && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_process_index <= p;
        s_priority_req  <= prio;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        got = run_queue_apply(op, p, prio);
        pending_results.push_back(known ? typed : got);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: checks each result beat, then picks m_ready for the next cycle.
    always @(posedge aclk) begin : result_side
        run_result_t e;
        int          rx_cycle;
        int          hold_left;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, mask %h error %0d",
                         $time, m_nonempty_mask, m_error);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_nonempty_mask !== e.mask) begin
                    $display("%0t: nonempty_mask expected %h actual %h",
                             $time, e.mask, m_nonempty_mask);
                    fail_count++;
                end
                if (m_error !== e.err) begin
                    $display("%0t: error expected %0d actual %0d", $time, e.err, m_error);
                    fail_count++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle == HOLD_AT)
            hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (calm_run) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : stimulus
        prq_pkg::prq_op_t      op;
        logic [PROC_IDX_W-1:0] p;
        logic [PRIO_W-1:0]     prio;
        int                    pick;
        int                    queued_procs[$];
        run_result_t           typed;

        directed_rows = '{
            '{prq_pkg::OP_REMOVE, 6'd0,  7'd0,   1'b1, 32'h0000_0000, prq_pkg::ERR_EMPTY_LEVEL},
            '{prq_pkg::OP_INSERT, 6'd0,  7'd0,   1'b1, 32'h0000_0001, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd0,  7'd0,   1'b1, 32'h0000_0001, prq_pkg::ERR_DUP_INSERT},
            '{prq_pkg::OP_INSERT, 6'd63, 7'd127, 1'b1, 32'h8000_0001, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd5,  7'd0,   1'b1, 32'h8000_0001, prq_pkg::ERR_NOT_QUEUED},
            '{prq_pkg::OP_REMOVE, 6'd63, 7'd127, 1'b1, 32'h0000_0001, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd1,  7'd1,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd2,  7'd3,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd1,  7'd2,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd0,  7'd0,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd10, 7'h55,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd10, 7'h2A,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd20, 7'h28,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd10, 7'h28,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd42, 7'h54,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd2,  7'd0,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd20, 7'h28,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd42, 7'h54,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd21, 7'h7F,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd22, 7'h7C,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_INSERT, 6'd21, 7'd0,   1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd22, 7'h7F,  1'b0, 32'h0, prq_pkg::ERR_OK},
            '{prq_pkg::OP_REMOVE, 6'd21, 7'h7D,  1'b0, 32'h0, prq_pkg::ERR_OK}
        };
        run_queue_reset();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            typed.mask = directed_rows[i].mask;
            typed.err  = directed_rows[i].err;
            offer_request(directed_rows[i].op, directed_rows[i].proc,
                          directed_rows[i].prio, directed_rows[i].known, typed);
        end
        drain_results();

        typed = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm_run = (i >= 1000 && i < 1300);
            if (i == 1500)
                drain_results();
            queued_procs.delete();
            for (int k = 0; k < NUM_PROCS; k++)
                if (in_queue[k])
                    queued_procs.push_back(k);
            pick = $urandom_range(99);
            if (pick < 15) begin
                // Noise: any request, including removes on the wrong level.
                op   = prq_pkg::prq_op_t'($urandom_range(1));
                p    = PROC_IDX_W'($urandom_range(NUM_PROCS - 1));
                prio = PRIO_W'($urandom_range(127));
            end else if (pick < 55 || queued_procs.size() == 0) begin
                op = prq_pkg::OP_INSERT;
                p  = PROC_IDX_W'($urandom_range(NUM_PROCS - 1));
                for (int k = 0; k < 8 && in_queue[p]; k++)
                    p = PROC_IDX_W'($urandom_range(NUM_PROCS - 1));
                // Half go to the lowest levels so that rings grow long.
                if ($urandom_range(1))
                    prio = PRIO_W'($urandom_range(15));
                else
                    prio = PRIO_W'($urandom_range(127));
            end else begin
                op   = prq_pkg::OP_REMOVE;
                p    = PROC_IDX_W'(queued_procs[$urandom_range(queued_procs.size() - 1)]);
                prio = {home_level[p], 2'($urandom_range(3))};
            end
            offer_request(op, p, prio, 1'b0, typed);
        end
        calm_run = 1'b0;
        drain_results();
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("priority_run_queue_core verification clean");
        end else begin
            $display("priority_run_queue_core verification failed");
        end
        $finish;
    end

endmodule
